// ----- design/mbrtu_pkg.sv -----
// Package for the RTU slave responder: shared types, codes and the initial register table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_WR_HR = 2'd2;
    localparam logic [1:0] CMD_WR_IR = 2'd3;

    localparam logic [7:0] FN_HOLDING = 8'd3;
    localparam logic [7:0] FN_INPUT   = 8'd4;
    localparam logic [7:0] EXC_FLAG   = 8'h80;
    localparam logic [7:0] EXC_ADDR   = 8'd2;
    localparam logic [7:0] EXC_VALUE  = 8'd3;
    localparam int unsigned MAX_WORDS = 125;

    localparam logic [1:0] CFG_ADDR  = 2'd0;
    localparam logic [1:0] CFG_ORDER = 2'd1;

    // datapath commands from the controller
    typedef struct packed {
        logic rx_byte;     // absorb one frame byte
        logic rx_restart;  // clear length and CRC
        logic tbl_write;   // write a table word
        logic ld_hdr;      // load header unit into output register
        logic ld_exc;      // load exception header
        logic rd_word;     // issue table read of current word
        logic ld_word;     // load data unit from read data
        logic ld_crc;      // load CRC unit
        logic crc_init;    // seed transmit CRC with address
    } mbrtu_cmd_t;

    typedef struct packed {
        logic frame_ok;    // length, CRC, address, function and length fine
        logic exc;         // request gives an exception
        logic words_done;  // last word has been read
        logic out_busy;    // output register still holds a unit
    } mbrtu_sts_t;

    function automatic logic [15:0] init_word(input logic [5:0] i);
        logic [15:0] v;
        begin
            v = 16'd0;
            unique case (i)
                6'd0: v = 16'd0;     6'd1: v = 16'd1111;  6'd2: v = 16'd2222;
                6'd3: v = 16'd3333;  6'd4: v = 16'd4444;  6'd5: v = 16'd5555;
                6'd6: v = 16'd6666;  6'd7: v = 16'd7777;  6'd8: v = 16'd8888;
                6'd9: v = 16'd9999;  6'd10: v = 16'd12345; 6'd11: v = 16'd15432;
                6'd12: v = 16'd15535; 6'd13: v = 16'd10234; 6'd14: v = 16'd19876;
                6'd15: v = 16'd13579; 6'd16: v = 16'd10293; 6'd17: v = 16'd19827;
                6'd18: v = 16'd13456; 6'd19: v = 16'd14567; 6'd20: v = 16'd21345;
                6'd21: v = 16'd22345; 6'd22: v = 16'd24567; 6'd23: v = 16'd25678;
                6'd24: v = 16'd26789; 6'd25: v = 16'd24680; 6'd26: v = 16'd20394;
                6'd27: v = 16'd29384; 6'd28: v = 16'd26937; 6'd29: v = 16'd27654;
                6'd30: v = 16'd31245; 6'd31: v = 16'd31456; 6'd32: v = 16'd34567;
                6'd33: v = 16'd35678; 6'd34: v = 16'd36789; 6'd35: v = 16'd37890;
                6'd36: v = 16'd30948; 6'd37: v = 16'd34958; 6'd38: v = 16'd35867;
                6'd39: v = 16'd36092; 6'd40: v = 16'd45678; 6'd41: v = 16'd46789;
                6'd42: v = 16'd47890; 6'd43: v = 16'd41235; 6'd44: v = 16'd42356;
                6'd45: v = 16'd43567; 6'd46: v = 16'd40596; 6'd47: v = 16'd49586;
                6'd48: v = 16'd48765; 6'd49: v = 16'd41029;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        begin
            r = c ^ {8'd0, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/mbrtu_datapath.sv -----
// Datapath of the RTU slave responder: receive capture, CRC, register tables, output unit.
// Depends on mbrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_datapath
    import mbrtu_pkg::*;
#(
    parameter int REG_COUNT = 50,
    parameter int MAX_FRAME = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mbrtu_cmd_t  cmd,
    output mbrtu_sts_t       sts,
    input  wire logic [1:0]  in_cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic [5:0]  in_index,
    input  wire logic [15:0] in_value,
    input  wire logic [7:0]  slave_addr,
    input  wire logic        word_order,
    input  wire logic        out_take,
    output logic             out_valid,
    output logic [7:0]       out_a,
    output logic [7:0]       out_b,
    output logic [7:0]       out_c,
    output logic [1:0]       out_cnt,
    output logic             out_last
);

    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [LW-1:0] len_reg;
    logic [7:0]    head_reg [6];
    logic [7:0]    tail_reg [2];
    logic [15:0]   crc_reg;
    logic [15:0]   txcrc_reg;
    logic [5:0]    ptr_reg;
    logic [6:0]    left_reg;

    // tables start from the fixed image; valid bits mark entries written since reset
    logic [15:0] hr_mem [REG_COUNT];
    logic [15:0] ir_mem [REG_COUNT];
    logic [REG_COUNT-1:0] hr_vld_reg, ir_vld_reg;
    logic [15:0] hr_rd_reg, ir_rd_reg;
    logic        hr_rdv_reg, ir_rdv_reg;
    logic [5:0]  rd_idx;
    logic        sel_ir_reg;

    logic [15:0] start_w, count_w;
    logic [16:0] end_w;
    logic        val_bad, addr_bad;

    assign start_w = {head_reg[2], head_reg[3]};
    assign count_w = {head_reg[4], head_reg[5]};
    assign end_w   = {1'b0, start_w} + {1'b0, count_w};
    assign val_bad = (count_w == 16'd0) || (count_w > 16'(MAX_WORDS));
    assign addr_bad = end_w > 17'(REG_COUNT);
    assign sts.exc  = val_bad || addr_bad;
    assign sts.frame_ok = (len_reg >= LW'(4)) && (tail_reg[0] == crc_reg[7:0])
        && (tail_reg[1] == crc_reg[15:8]) && (head_reg[0] == slave_addr)
        && (head_reg[1] == FN_HOLDING || head_reg[1] == FN_INPUT)
        && (len_reg >= LW'(8));
    assign sts.words_done = (left_reg == 7'd0);
    assign sts.out_busy   = out_valid && !out_take;

    // receive side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            crc_reg <= 16'hFFFF;
        end
        else if (cmd.rx_restart)
        begin
            len_reg <= '0;
            crc_reg <= 16'hFFFF;
        end
        else if (cmd.rx_byte && len_reg < LW'(MAX_FRAME))
        begin
            if (len_reg >= LW'(2))
                crc_reg <= crc_byte(crc_reg, tail_reg[0]);
            len_reg <= len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_byte && len_reg < LW'(MAX_FRAME))
        begin
            if (len_reg < LW'(6))
                head_reg[len_reg[2:0]] <= in_byte;
            tail_reg[0] <= tail_reg[1];
            tail_reg[1] <= in_byte;
        end
    end

    // tables
    assign rd_idx = ptr_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write && in_cmd == CMD_WR_HR && in_index < 6'(REG_COUNT))
            hr_mem[in_index] <= in_value;
        if (cmd.tbl_write && in_cmd == CMD_WR_IR && in_index < 6'(REG_COUNT))
            ir_mem[in_index] <= in_value;
        if (cmd.rd_word)
        begin
            hr_rd_reg <= hr_mem[rd_idx];
            ir_rd_reg <= ir_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hr_vld_reg <= '0;
            ir_vld_reg <= '0;
            hr_rdv_reg <= 1'b0;
            ir_rdv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tbl_write && in_cmd == CMD_WR_HR && in_index < 6'(REG_COUNT))
                hr_vld_reg[in_index] <= 1'b1;
            if (cmd.tbl_write && in_cmd == CMD_WR_IR && in_index < 6'(REG_COUNT))
                ir_vld_reg[in_index] <= 1'b1;
            if (cmd.rd_word)
            begin
                hr_rdv_reg <= hr_vld_reg[rd_idx];
                ir_rdv_reg <= ir_vld_reg[rd_idx];
            end
        end
    end

    logic [15:0] word_v, init_q_reg;
    logic [7:0]  b0, b1;
    always_ff @(posedge clk)
    begin
        if (cmd.rd_word)
            init_q_reg <= init_word(rd_idx);
    end
    assign word_v = sel_ir_reg ? (ir_rdv_reg ? ir_rd_reg : init_q_reg)
                               : (hr_rdv_reg ? hr_rd_reg : init_q_reg);
    assign b0 = word_order ? word_v[15:8] : word_v[7:0];
    assign b1 = word_order ? word_v[7:0] : word_v[15:8];

    // transmit side
    logic [7:0] efn, h2;
    assign efn = head_reg[1] | EXC_FLAG;
    assign h2  = {count_w[6:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid  <= 1'b0;
            out_a      <= 8'd0;
            out_b      <= 8'd0;
            out_c      <= 8'd0;
            out_cnt    <= 2'd0;
            out_last   <= 1'b0;
            left_reg   <= '0;
            ptr_reg    <= '0;
            sel_ir_reg <= 1'b0;
            txcrc_reg  <= 16'hFFFF;
        end
        else
        begin
            if (out_take)
                out_valid <= 1'b0;
            if (cmd.crc_init)
                txcrc_reg <= crc_byte(16'hFFFF, slave_addr);
            if (cmd.ld_exc)
            begin
                out_valid <= 1'b1;
                out_a <= slave_addr;
                out_b <= efn;
                out_c <= val_bad ? EXC_VALUE : EXC_ADDR;
                out_cnt <= 2'd3;
                out_last <= 1'b0;
                txcrc_reg <= crc_byte(crc_byte(txcrc_reg, efn), val_bad ? EXC_VALUE : EXC_ADDR);
            end
            else if (cmd.ld_hdr)
            begin
                out_valid <= 1'b1;
                out_a <= slave_addr;
                out_b <= head_reg[1];
                out_c <= h2;
                out_cnt <= 2'd3;
                out_last <= 1'b0;
                txcrc_reg <= crc_byte(crc_byte(txcrc_reg, head_reg[1]), h2);
                ptr_reg <= start_w[5:0];
                left_reg <= count_w[6:0];
                sel_ir_reg <= (head_reg[1] == FN_INPUT);
            end
            else if (cmd.ld_word)
            begin
                out_valid <= 1'b1;
                out_a <= b0;
                out_b <= b1;
                out_c <= 8'd0;
                out_cnt <= 2'd2;
                out_last <= 1'b0;
                txcrc_reg <= crc_byte(crc_byte(txcrc_reg, b0), b1);
            end
            else if (cmd.ld_crc)
            begin
                out_valid <= 1'b1;
                out_a <= txcrc_reg[7:0];
                out_b <= txcrc_reg[15:8];
                out_c <= 8'd0;
                out_cnt <= 2'd2;
                out_last <= 1'b1;
            end
            if (cmd.rd_word)
            begin
                ptr_reg <= ptr_reg + 6'd1;
                left_reg <= left_reg - 7'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/mbrtu_ctrl.sv -----
// Controller of the RTU slave responder: sequences receive, table writes and response units.
// Depends on mbrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_ctrl
    import mbrtu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_cmd,
    input  wire mbrtu_sts_t sts,
    output mbrtu_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_READ  = 6'b000100,
        S_WAIT  = 6'b001000,
        S_WORD  = 6'b010000,
        S_CRC   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   exc_reg, exc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            exc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            exc_reg   <= exc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        exc_next   = exc_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_BYTE: cmd.rx_byte = 1'b1;
                        CMD_END:  state_next = S_CHECK;
                        default:  cmd.tbl_write = 1'b1;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (!sts.frame_ok)
                begin
                    cmd.rx_restart = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.crc_init = 1'b1;
                    exc_next = sts.exc;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // header goes out once the output register is free
                if (!sts.out_busy)
                begin
                    if (exc_reg)
                    begin
                        cmd.ld_exc = 1'b1;
                        state_next = S_CRC;
                    end
                    else
                    begin
                        cmd.ld_hdr = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (sts.words_done)
                    state_next = S_CRC;
                else
                begin
                    cmd.rd_word = 1'b1;
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                if (!sts.out_busy)
                begin
                    cmd.ld_word = 1'b1;
                    state_next = S_READ;
                end
            end
            S_CRC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.ld_crc = 1'b1;
                    cmd.rx_restart = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/modbus_rtu_slave_responder_core.sv -----
// RTU slave responder for read holding/input registers with CRC-16.
// Frame bytes and table writes are accepted only while idle. A frame end goes through
// a check state and then loads the header; each data word is then a table read and a
// load, and the CRC unit follows the data or the exception header. Input is held off
// from frame end until the CRC unit is loaded or a bad frame is dropped; output stalls wait.
// Reset is asynchronous, active low: tables return to the fixed image, receive clears.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_responder_core
    import mbrtu_pkg::*;
#(
    parameter int REG_COUNT = 50,
    parameter int MAX_FRAME = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte[7:0], reg_index[13:8], reg_value[29:14]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_byte_a[7:0], out_byte_b[15:8], out_byte_c[23:16], byte_count[25:24]
    output logic             m_tlast    // last_unit
);

    logic [7:0] addr_reg;
    logic       order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 8'd1;
            order_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ADDR[0:0])
                addr_reg <= cfg_data;
            else
                order_reg <= cfg_data[0];
        end
    end

    mbrtu_cmd_t cmd;
    mbrtu_sts_t sts;
    logic [7:0] oa, ob, oc;
    logic [1:0] ocnt;

    mbrtu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .sts(sts), .cmd(cmd)
    );

    mbrtu_datapath #(.REG_COUNT(REG_COUNT), .MAX_FRAME(MAX_FRAME)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_cmd(s_tuser), .in_byte(s_tdata[7:0]), .in_index(s_tdata[13:8]),
        .in_value(s_tdata[29:14]), .slave_addr(addr_reg), .word_order(order_reg),
        .out_take(m_tready), .out_valid(m_tvalid), .out_a(oa), .out_b(ob), .out_c(oc),
        .out_cnt(ocnt), .out_last(m_tlast)
    );

    assign m_tdata = {6'd0, ocnt, oc, ob, oa};

endmodule
`default_nettype wire
